/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers. Each expects clk and arst_n in the scope where it is used.

// The condition holds at every clock edge outside reset.
`define FWCB_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FWCB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FWCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fwcb_pkg.sv */
`timescale 1ns / 1ps

package fwcb_pkg;

	// Request codes on func.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_CLOSE = 2'd1;
	localparam logic [1:0] FUNC_OPEN  = 2'd2;

	// Result codes on kind.
	localparam logic [1:0] KIND_ERASE = 2'd0;
	localparam logic [1:0] KIND_PROG  = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	localparam logic [4:0] SECTOR_LOG2_RESET = 5'd12;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [63:0] data;
	} result_t;

endpackage

/* sv/fwcb_page_ram.sv */
`timescale 1ns / 1ps

module fwcb_page_ram #(
	parameter int PAGE_BYTES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            wr_en,
	input  logic [$clog2(PAGE_BYTES)-1:0]   wr_idx,
	input  logic [7:0]                      wr_byte,
	input  logic                            rd_en,
	input  logic [$clog2(PAGE_BYTES)-4:0]   rd_row,
	input  logic [7:0]                      rd_keep,
	output logic [63:0]                     rd_word
);

	localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
	localparam int ROW_W     = PAGE_LOG2 - 3;
	localparam int ROWS      = PAGE_BYTES / 8;

	logic [63:0]      mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;
	logic [63:0]      rd_data_s1;
	logic             rd_valid_s1;
	logic [7:0]       rd_keep_s1;
	logic [ROW_W-1:0] wr_row;
	logic [2:0]       wr_lane;
	logic [63:0]      fill_row;

	assign wr_row  = wr_idx[PAGE_LOG2-1:3];
	assign wr_lane = wr_idx[2:0];

	// A row that has not been written since the last clear reads as erased flash.
	always_comb begin
		fill_row = '1;
		fill_row[{wr_lane, 3'b000} +: 8] = wr_byte;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (row_valid_q[wr_row]) begin
				mem[wr_row][{wr_lane, 3'b000} +: 8] <= wr_byte;
			end else begin
				mem[wr_row] <= fill_row;
			end
		end
		if (rd_en) begin
			rd_data_s1  <= mem[rd_row];
			rd_valid_s1 <= row_valid_q[rd_row];
			rd_keep_s1  <= rd_keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (clr) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_row] <= 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rd_word[8*i +: 8] = (rd_valid_s1 && rd_keep_s1[i]) ? rd_data_s1[8*i +: 8] : 8'hFF;
		end
	end

endmodule

/* sv/fwcb_result_reg.sv */
`timescale 1ns / 1ps

module fwcb_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fwcb_pkg::result_t push_res,
	input  logic              fin,
	output logic              result_strobe,
	output fwcb_pkg::result_t res,
	output logic              last
);

	logic              pend_valid_q;
	fwcb_pkg::result_t pend_q;
	logic              strobe_q;
	fwcb_pkg::result_t res_q;
	logic              last_q;

	// One result is held back so that the final one of a transaction can be
	// marked once the control logic knows nothing more follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (push) begin
				strobe_q     <= pend_valid_q;
				pend_valid_q <= 1'b1;
			end else if (fin) begin
				strobe_q     <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q  <= pend_q;
			last_q <= 1'b0;
			pend_q <= push_res;
		end else if (fin) begin
			res_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign res           = res_q;
	assign last          = last_q;

endmodule

/* sv/flash_write_combining_buffer.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Flash write-combining buffer with sector erase.
// A request is a transaction on start/busy: it is taken at a rising edge with start high
// and busy low, carrying func (write byte, close, open), byte_addr and data_byte.
// The block answers with a stream of results on kind, cmd_addr, word_data and last.
// Each result is valid for exactly one cycle while result_strobe is high; last marks
// the final result of a request. A write that needs no flash command gives no result.
// The receiver cannot stall: results are always taken, so no backpressure exists.
// The page buffer lives in a RAM of 64-bit rows with a registered read port and one
// valid bit per row, so clearing the buffer only resets the valid bits.
// A flush sends one program word per cycle, set by the one read port of the page RAM;
// a close flushes the buffer first and then adds the acknowledge.
// A result is held in a pending register until the next result or the request ends.
// The sector size register is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce this.
// Reset leaves the block closed with an empty buffer and the sector size log2 at 12.
// PAGE_BYTES must be a power of two between 64 and 4096.
module flash_write_combining_buffer #(
	parameter int PAGE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] byte_addr,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output logic        result_strobe,
	output logic [1:0]  kind,
	output logic [31:0] cmd_addr,
	output logic [63:0] word_data,
	output logic        last
);

	localparam int         PAGE_LOG2   = $clog2(PAGE_BYTES);
	localparam int         ROW_W       = PAGE_LOG2 - 3;
	localparam logic [4:0] PAGE_LOG2_V = 5'(PAGE_LOG2);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_FLUSH  = 3'd2;
	localparam logic [2:0] S_FTAIL  = 3'd3;
	localparam logic [2:0] S_CLOSE  = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	// Checks of a byte write, in the order they are applied.
	localparam logic [2:0] STEP_FIRST = 3'd0;
	localparam logic [2:0] STEP_BLK   = 3'd1;
	localparam logic [2:0] STEP_SEC   = 3'd2;
	localparam logic [2:0] STEP_BEND  = 3'd3;
	localparam logic [2:0] STEP_SEND  = 3'd4;
	localparam logic [2:0] STEP_STORE = 3'd5;

	// Bytes of the last word that lie inside a block shorter than one word.
	function automatic logic [7:0] keep_mask(input logic [4:0] blk_log2);
		logic [7:0] m;
		case (blk_log2)
			5'd0:    m = 8'h01;
			5'd1:    m = 8'h03;
			5'd2:    m = 8'h0F;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

	logic [2:0]  state_q;
	logic [2:0]  step_q;
	logic [4:0]  cfg_log2_q;
	logic [4:0]  latched_q;
	logic        is_open_q;
	logic        sector_valid_q;
	logic        buffer_empty_q;
	logic [31:0] prev_q;
	logic [31:0] block_base_q;
	logic [31:0] sector_base_q;
	logic [1:0]  func_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	logic [ROW_W-1:0] cnt_q;
	logic        rd_issue_s1;
	logic [31:0] word_addr_s1;

	logic        accept;
	logic [4:0]  blog;
	logic [4:0]  cfg_blog;
	logic [31:0] bmask;
	logic [31:0] smask;
	logic [31:0] cfg_bmask;
	logic [31:0] cfg_smask;
	logic [32:0] bs33;
	logic [32:0] ss33;
	logic [PAGE_LOG2-1:0] bs_m1;
	logic [ROW_W-1:0] last_row;
	logic        c_blk, c_sec, c_bend, c_send;
	logic        t_first, t_blk, t_sec, t_bend, t_send;
	logic        sel_first, sel_blk, sel_sec, sel_bend, sel_send, sel_store;
	logic        in_decide;
	logic        do_setup, do_flush, do_store;
	logic        err_acc, ack_acc;
	logic        push, fin, clr;
	fwcb_pkg::result_t push_res;
	fwcb_pkg::result_t res;
	logic [63:0] rd_word;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Block size is the smaller of the sector and the page.
	assign blog      = (latched_q < PAGE_LOG2_V) ? latched_q : PAGE_LOG2_V;
	assign cfg_blog  = (cfg_log2_q < PAGE_LOG2_V) ? cfg_log2_q : PAGE_LOG2_V;
	assign bmask     = 32'hFFFF_FFFF << blog;
	assign smask     = 32'hFFFF_FFFF << latched_q;
	assign cfg_bmask = 32'hFFFF_FFFF << cfg_blog;
	assign cfg_smask = 32'hFFFF_FFFF << cfg_log2_q;
	assign bs33      = 33'd1 << blog;
	assign ss33      = 33'd1 << latched_q;
	assign bs_m1     = ~({PAGE_LOG2{1'b1}} << blog);
	assign last_row  = bs_m1[PAGE_LOG2-1:3];

	// All checks look at the current state; the first one that fires acts this
	// cycle and the rest are looked at again once its effect is in the registers.
	assign c_blk  = (addr_q & bmask) != (prev_q & bmask);
	assign c_sec  = (addr_q & smask) != (prev_q & smask);
	assign c_bend = {1'b0, addr_q} >= ({1'b0, block_base_q} + bs33);
	assign c_send = {1'b0, addr_q} >= ({1'b0, sector_base_q} + ss33);

	assign t_first = (step_q == STEP_FIRST) && !sector_valid_q;
	assign t_blk   = (step_q <= STEP_BLK) && c_blk;
	assign t_sec   = (step_q <= STEP_SEC) && c_sec;
	assign t_bend  = (step_q <= STEP_BEND) && c_bend;
	assign t_send  = (step_q <= STEP_SEND) && c_send;

	assign sel_first = t_first;
	assign sel_blk   = !t_first && t_blk;
	assign sel_sec   = !t_first && !t_blk && t_sec;
	assign sel_bend  = !t_first && !t_blk && !t_sec && t_bend;
	assign sel_send  = !t_first && !t_blk && !t_sec && !t_bend && t_send;
	assign sel_store = !t_first && !t_blk && !t_sec && !t_bend && !t_send;

	assign in_decide = (state_q == S_DECIDE);
	assign do_setup  = in_decide && (sel_first || sel_sec || sel_send);
	assign do_flush  = in_decide && (sel_blk || sel_bend);
	assign do_store  = in_decide && sel_store;

	assign ack_acc = (func == fwcb_pkg::FUNC_OPEN) && !is_open_q;
	assign err_acc = !ack_acc && !((func == fwcb_pkg::FUNC_CLOSE || func == fwcb_pkg::FUNC_WRITE)
		&& is_open_q);

	// The page buffer is emptied by every sector setup, every flush and every
	// open or close that resets the whole state.
	assign clr = do_setup || (do_flush && buffer_empty_q) || (state_q == S_FTAIL)
		|| (state_q == S_IDLE && accept && ack_acc)
		|| (state_q == S_CLOSE && buffer_empty_q);

	assign fin = (state_q == S_FIN) || do_store;

	always_comb begin
		push     = 1'b0;
		push_res = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && (ack_acc || err_acc)) begin
					push          = 1'b1;
					push_res.kind = ack_acc ? fwcb_pkg::KIND_ACK : fwcb_pkg::KIND_ERR;
				end
			end
			S_DECIDE: begin
				if (do_setup) begin
					push          = 1'b1;
					push_res.kind = fwcb_pkg::KIND_ERASE;
					push_res.addr = addr_q & cfg_smask;
				end
			end
			S_CLOSE: begin
				if (buffer_empty_q) begin
					push          = 1'b1;
					push_res.kind = fwcb_pkg::KIND_ACK;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
		// Read data of a flush returns in the cycle after its row was addressed.
		if (rd_issue_s1) begin
			push          = 1'b1;
			push_res.kind = fwcb_pkg::KIND_PROG;
			push_res.addr = word_addr_s1;
			push_res.data = rd_word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			addr_q <= byte_addr;
			data_q <= data_byte;
		end
		word_addr_s1 <= block_base_q + 32'({cnt_q, 3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= STEP_FIRST;
			cfg_log2_q     <= fwcb_pkg::SECTOR_LOG2_RESET;
			latched_q      <= fwcb_pkg::SECTOR_LOG2_RESET;
			is_open_q      <= 1'b0;
			sector_valid_q <= 1'b0;
			buffer_empty_q <= 1'b1;
			prev_q         <= '0;
			block_base_q   <= '0;
			sector_base_q  <= '0;
			cnt_q          <= '0;
			rd_issue_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_log2_q <= cfg_wdata;
			end
			rd_issue_s1 <= (state_q == S_FLUSH);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							fwcb_pkg::FUNC_OPEN: begin
								if (!is_open_q) begin
									is_open_q      <= 1'b1;
									sector_valid_q <= 1'b0;
									buffer_empty_q <= 1'b1;
									prev_q         <= '0;
									block_base_q   <= '0;
									sector_base_q  <= '0;
								end
								state_q <= S_FIN;
							end
							fwcb_pkg::FUNC_CLOSE: begin
								state_q <= is_open_q ? S_CLOSE : S_FIN;
							end
							fwcb_pkg::FUNC_WRITE: begin
								step_q  <= STEP_FIRST;
								state_q <= is_open_q ? S_DECIDE : S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_DECIDE: begin
					// A sector setup takes the size from the register at this point.
					if (do_setup) begin
						latched_q     <= cfg_log2_q;
						sector_base_q <= addr_q & cfg_smask;
						block_base_q  <= addr_q & cfg_bmask;
					end
					if (sel_first) begin
						sector_valid_q <= 1'b1;
						prev_q         <= addr_q;
						step_q         <= STEP_BLK;
					end else if (sel_blk) begin
						step_q <= STEP_SEC;
					end else if (sel_sec) begin
						step_q <= STEP_BEND;
					end else if (sel_bend) begin
						step_q <= STEP_SEND;
					end else if (sel_send) begin
						step_q <= STEP_STORE;
					end
					if (do_flush) begin
						if (buffer_empty_q) begin
							block_base_q <= addr_q & bmask;
						end else begin
							state_q <= S_FLUSH;
						end
					end
					if (do_store) begin
						if (addr_q < block_base_q) begin
							block_base_q <= addr_q & bmask;
						end
						buffer_empty_q <= 1'b0;
						prev_q         <= addr_q + 32'd1;
						state_q        <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (cnt_q == last_row) begin
						cnt_q   <= '0;
						state_q <= S_FTAIL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FTAIL: begin
					buffer_empty_q <= 1'b1;
					block_base_q   <= addr_q & bmask;
					state_q        <= (func_q == fwcb_pkg::FUNC_CLOSE) ? S_CLOSE : S_DECIDE;
				end
				S_CLOSE: begin
					if (buffer_empty_q) begin
						is_open_q      <= 1'b0;
						sector_valid_q <= 1'b0;
						prev_q         <= '0;
						block_base_q   <= '0;
						sector_base_q  <= '0;
						state_q        <= S_FIN;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	fwcb_page_ram #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_page_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.wr_en   (do_store),
		.wr_idx  (addr_q[PAGE_LOG2-1:0] & bs_m1),
		.wr_byte (data_q),
		.rd_en   (state_q == S_FLUSH),
		.rd_row  (cnt_q),
		.rd_keep (keep_mask(blog)),
		.rd_word (rd_word)
	);

	fwcb_result_reg u_result_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_res      (push_res),
		.fin           (fin),
		.result_strobe (result_strobe),
		.res           (res),
		.last          (last)
	);

	assign kind      = res.kind;
	assign cmd_addr  = res.addr;
	assign word_data = res.data;

	// A result formed in the completing cycle would be lost behind the last flag.
	`FWCB_ASSERT_ALWAYS(a_no_push_at_fin, !(push && fin), "result formed while completing")
	// A closed buffer holds no data and no sector.
	`FWCB_ASSERT_IMPL(a_closed_clean, !is_open_q, buffer_empty_q && !sector_valid_q, "closed buffer holds state")
	// The block base always sits on a boundary of the current block size.
	`FWCB_ASSERT_ALWAYS(a_block_aligned, (block_base_q & ~bmask) == 32'd0, "block base misaligned")
	// Bytes are only stored into an open buffer with a sector set up.
	`FWCB_ASSERT_IMPL(a_store_open, do_store, is_open_q && sector_valid_q, "byte stored without sector")

endmodule
